// ===== design/mts_pkg.sv =====
package mts_pkg;

  // Command codes of an input transaction.
  localparam logic [1:0] CMD_SET  = 2'd0;
  localparam logic [1:0] CMD_KILL = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Status codes of a result transaction.
  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_NO_SLOT    = 2'd1;
  localparam logic [1:0] ST_KILL_IGN   = 2'd2;
  localparam logic [1:0] ST_LIST_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] period;
    logic [31:0] repeat_count;
    logic [31:0] user_tag;
    logic [3:0]  target_slot;
    logic [31:0] now_time;
    logic        accept_fire;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_number;
    logic        fired;
    logic [31:0] fired_tag;
    logic        retired;
  } out_item_t;

  // Operation class decided by the front end.
  typedef enum logic [1:0] {
    OP_SET,
    OP_KILL,
    OP_TICK,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t      op;
    in_item_t item;
  } q_item_t;

  // Back-end sequencer states.
  typedef enum logic {
    BK_READ,
    BK_EXEC
  } bk_state_t;

endpackage

// ===== design/mts_front.sv =====
module mts_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mts_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output mts_pkg::q_item_t  q_data
);
  import mts_pkg::*;

  q_item_t    buf_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;
  q_item_t    entry;

  // Classify the command of each incoming transaction.
  always_comb begin
    entry.item = in_data;
    case (in_data.cmd)
      CMD_SET:  entry.op = OP_SET;
      CMD_KILL: entry.op = OP_KILL;
      CMD_TICK: entry.op = OP_TICK;
      default:  entry.op = OP_NOP;
    endcase
  end

  // Two-entry queue toward the back end.
  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_data   = buf_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= entry;
    end
  end

endmodule

// ===== design/mts_back.sv =====
module mts_back #(
  parameter int TIMER_SLOTS = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  mts_pkg::q_item_t   q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mts_pkg::out_item_t out_data
);
  import mts_pkg::*;

  localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  // Slot record and link memories.
  logic [31:0]          int_mem  [TIMER_SLOTS];
  logic [31:0]          rem_mem  [TIMER_SLOTS];
  logic [TIME_BITS-1:0] base_mem [TIMER_SLOTS];
  logic [31:0]          tag_mem  [TIMER_SLOTS];
  logic [SW-1:0]        fwd_mem  [TIMER_SLOTS];
  logic [SW-1:0]        bwd_mem  [TIMER_SLOTS];

  logic [31:0]          int_q, rem_q, tag_q;
  logic [TIME_BITS-1:0] base_q;
  logic [SW-1:0]        fwd_q, bwd_q;

  bk_state_t state_r, state_nxt;
  logic      pop, exec_fire;

  logic [TIMER_SLOTS-1:0] in_use_r, in_use_nxt;
  logic [SW-1:0]          head_r, head_nxt, tail_r, tail_nxt, scan_pos_r, scan_pos_nxt;
  logic                   nonempty_r, nonempty_nxt, scan_valid_r, scan_valid_nxt;

  op_t           op_r;
  in_item_t      item_r;
  logic [SW-1:0] s_r;
  logic          full_r, empty_r, kill_ok_r;

  logic          out_valid_r;
  out_item_t     out_data_r;

  // Front-of-back decode signals.
  logic [SW-1:0]   free_idx, sel_s, tgt_idx;
  logic            free_found, restart, tgt_in_range;
  logic [SW+3:0]   tgt_ext;

  // Execute-cycle signals.
  out_item_t            res;
  logic                 do_adv, do_unlink, retire, due;
  logic                 rec_we, fwd_we, bwd_we;
  logic [31:0]          rec_int, rec_rem, rec_tag;
  logic [TIME_BITS-1:0] rec_base, now_t, diff;
  logic [TIME_BITS+31:0] now_ext;
  logic [SW-1:0]        fwd_waddr, fwd_wdata, bwd_waddr, bwd_wdata;
  logic [SW+3:0]        slot_ext;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_READ: if (q_valid) state_nxt = BK_EXEC;
      BK_EXEC: if (!out_valid_r || out_ready) state_nxt = BK_READ;
      default: state_nxt = BK_READ;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pop       = 1'b0;
    exec_fire = 1'b0;
    case (state_r)
      BK_READ: pop = q_valid;
      BK_EXEC: exec_fire = !out_valid_r || out_ready;
      default: ;
    endcase
  end
  assign q_ready = (state_r == BK_READ);

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // Pick the slot that this transaction works on.
  assign tgt_ext      = {{SW{1'b0}}, q_data.item.target_slot};
  assign tgt_idx      = tgt_ext[SW-1:0];
  assign tgt_in_range = (tgt_ext < (SW+4)'(TIMER_SLOTS));
  assign restart      = !scan_valid_r || !in_use_r[scan_pos_r];

  always_comb begin
    case (q_data.op)
      OP_SET:  sel_s = free_idx;
      OP_KILL: sel_s = tgt_idx;
      OP_TICK: sel_s = restart ? head_r : scan_pos_r;
      default: sel_s = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op_r      <= q_data.op;
      item_r    <= q_data.item;
      s_r       <= sel_s;
      full_r    <= !free_found;
      empty_r   <= restart && !nonempty_r;
      kill_ok_r <= tgt_in_range && in_use_r[tgt_idx];
      int_q     <= int_mem[sel_s];
      rem_q     <= rem_mem[sel_s];
      base_q    <= base_mem[sel_s];
      tag_q     <= tag_mem[sel_s];
      fwd_q     <= fwd_mem[sel_s];
      bwd_q     <= bwd_mem[sel_s];
    end
  end

  // Execute one command on the slot and its links.
  assign now_ext  = {{TIME_BITS{1'b0}}, item_r.now_time};
  assign now_t    = now_ext[TIME_BITS-1:0];
  assign diff     = now_t - base_q;
  assign due      = ({{32{1'b0}}, diff} >= {{TIME_BITS{1'b0}}, int_q});
  assign slot_ext = {4'b0000, s_r};

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    nonempty_nxt   = nonempty_r;
    scan_pos_nxt   = scan_pos_r;
    scan_valid_nxt = scan_valid_r;
    in_use_nxt     = in_use_r;
    rec_we         = 1'b0;
    rec_int        = int_q;
    rec_rem        = rem_q;
    rec_tag        = tag_q;
    rec_base       = base_q;
    fwd_we         = 1'b0;
    fwd_waddr      = s_r;
    fwd_wdata      = s_r;
    bwd_we         = 1'b0;
    bwd_waddr      = s_r;
    bwd_wdata      = s_r;
    res            = '0;
    do_adv         = 1'b0;
    do_unlink      = 1'b0;
    retire         = 1'b0;
    case (op_r)
      OP_SET: begin
        if (full_r) begin
          res.status = ST_NO_SLOT;
        end else begin
          in_use_nxt[s_r] = 1'b1;
          rec_we          = 1'b1;
          rec_int         = item_r.period;
          rec_rem         = item_r.repeat_count;
          rec_tag         = item_r.user_tag;
          rec_base        = now_t;
          if (nonempty_r) begin
            bwd_we    = 1'b1;
            bwd_wdata = tail_r;
            fwd_we    = 1'b1;
            fwd_waddr = tail_r;
            fwd_wdata = s_r;
          end else begin
            head_nxt     = s_r;
            nonempty_nxt = 1'b1;
          end
          tail_nxt        = s_r;
          res.slot_number = slot_ext[3:0];
        end
      end
      OP_KILL: begin
        res.slot_number = item_r.target_slot;
        if (!kill_ok_r) begin
          res.status = ST_KILL_IGN;
        end else begin
          do_adv      = scan_valid_r && (scan_pos_r == s_r);
          do_unlink   = 1'b1;
          res.retired = 1'b1;
        end
      end
      OP_TICK: begin
        if (empty_r) begin
          scan_valid_nxt = 1'b0;
          scan_pos_nxt   = '0;
          res.status     = ST_LIST_EMPTY;
        end else begin
          res.slot_number = slot_ext[3:0];
          do_adv          = 1'b1;
          if (due) begin
            res.fired     = 1'b1;
            res.fired_tag = tag_q;
            if (item_r.accept_fire) begin
              rec_we   = 1'b1;
              rec_base = now_t;
              if (rem_q != 32'd0) begin
                rec_rem = rem_q - 32'd1;
                retire  = (rem_q == 32'd1);
              end
            end else begin
              retire = 1'b1;
            end
            do_unlink   = retire;
            res.retired = retire;
          end
        end
      end
      default: ;
    endcase

    // Move the scan past the slot before it is unlinked.
    if (do_adv) begin
      if (s_r == tail_r) begin
        scan_valid_nxt = 1'b0;
        scan_pos_nxt   = '0;
      end else begin
        scan_valid_nxt = 1'b1;
        scan_pos_nxt   = fwd_q;
      end
    end

    // Remove the slot from the list and free it.
    if (do_unlink) begin
      in_use_nxt[s_r] = 1'b0;
      if ((s_r == head_r) && (s_r == tail_r)) begin
        nonempty_nxt = 1'b0;
        head_nxt     = '0;
        tail_nxt     = '0;
      end else if (s_r == head_r) begin
        head_nxt = fwd_q;
      end else if (s_r == tail_r) begin
        tail_nxt = bwd_q;
      end else begin
        fwd_we    = 1'b1;
        fwd_waddr = bwd_q;
        fwd_wdata = fwd_q;
        bwd_we    = 1'b1;
        bwd_waddr = fwd_q;
        bwd_wdata = bwd_q;
      end
    end
  end

  // Memory writes at commit.
  always_ff @(posedge clk) begin
    if (exec_fire && rec_we) begin
      int_mem[s_r]  <= rec_int;
      rem_mem[s_r]  <= rec_rem;
      base_mem[s_r] <= rec_base;
      tag_mem[s_r]  <= rec_tag;
    end
    if (exec_fire && fwd_we) begin
      fwd_mem[fwd_waddr] <= fwd_wdata;
    end
    if (exec_fire && bwd_we) begin
      bwd_mem[bwd_waddr] <= bwd_wdata;
    end
  end

  // Control state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_READ;
      in_use_r     <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      nonempty_r   <= 1'b0;
      scan_pos_r   <= '0;
      scan_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_fire) begin
        in_use_r     <= in_use_nxt;
        head_r       <= head_nxt;
        tail_r       <= tail_nxt;
        nonempty_r   <= nonempty_nxt;
        scan_pos_r   <= scan_pos_nxt;
        scan_valid_r <= scan_valid_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/multi_timer_scheduler_unit.sv =====
// Timer table with slots chained in insertion order.
// Input channel in_valid/in_ready/in_data carries set, kill and tick
// commands; each transaction yields exactly one result transaction on
// out_valid/out_ready/out_data, in order.
// A set takes the lowest free slot and appends it to the list; a kill frees
// an active slot; a tick examines the next timer of the round-robin scan and
// fires it when now minus its base time reaches its period.
// The front end classifies commands into a two-entry queue. The back end
// sequencer handles each command in BK_READ, which reads the slot record and
// links from the slot memories, then in BK_EXEC, which updates them and
// registers the result. It takes the next command from the queue only after
// the current one has executed; meanwhile the queue accepts commands until full.
// When the receiver stalls, the result register holds, the sequencer waits
// and the queue fills; in_ready falls once two commands are queued.
// Reset (synchronous, rst_n low) empties the queue, frees every slot and
// invalidates the scan; slot memories need no clearing.
module multi_timer_scheduler_unit #(
  parameter int TIMER_SLOTS = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mts_pkg::out_item_t out_data
);
  import mts_pkg::*;

  logic    q_valid, q_ready;
  q_item_t q_data;

  mts_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  mts_back #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // An empty-list tick neither fires nor frees a slot.
  a_empty_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_LIST_EMPTY) |-> !out_data.fired && !out_data.retired)
    else $error("empty-list result fired or retired");

  // A result that did not fire carries no tag.
  a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.fired |-> (out_data.fired_tag == 32'd0))
    else $error("tag on a result that did not fire");

  // A refused set reports slot zero and frees nothing.
  a_full_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_NO_SLOT) |->
      (out_data.slot_number == 4'd0) && !out_data.retired && !out_data.fired)
    else $error("table-full result not clean");
`endif

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mts_pkg::*;

  localparam int SLOTS = 16;
  localparam int CYCLE_LIMIT = 400000;

  // Golden timer-table model and queue of predicted results.
  class timer_table_sb;
    bit          busy[SLOTS];
    logic [31:0] ivl[SLOTS];
    logic [31:0] left[SLOTS];
    logic [31:0] base[SLOTS];
    logic [31:0] tag[SLOTS];
    logic [3:0]  nxt[SLOTS];
    logic [3:0]  prv[SLOTS];
    logic [3:0]  head, tail, scan;
    bit          nonempty, scan_ok;
    out_item_t   pending[$];
    int          errors;

    function new();
      foreach (busy[i]) busy[i] = 0;
      head = 0; tail = 0; scan = 0; nonempty = 0; scan_ok = 0; errors = 0;
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    function int active_count();
      int n;
      n = 0;
      foreach (busy[i]) n += busy[i];
      return n;
    endfunction

    function void unlink(logic [3:0] s);
      if (s == head && s == tail) begin
        nonempty = 0; head = 0; tail = 0;
      end else if (s == head) begin
        head = nxt[s];
      end else if (s == tail) begin
        tail = prv[s];
      end else begin
        nxt[prv[s]] = nxt[s];
        prv[nxt[s]] = prv[s];
      end
      busy[s] = 0;
    endfunction

    function void step_scan(logic [3:0] s);
      if (s == tail) begin
        scan_ok = 0; scan = 0;
      end else begin
        scan = nxt[s]; scan_ok = 1;
      end
    endfunction

    // Apply one accepted input transaction and queue its result.
    function void note_input(in_item_t it);
      out_item_t r;
      int s;
      r = '0;
      case (it.cmd)
        CMD_SET: begin
          s = 0;
          while (s < SLOTS && busy[s]) s++;
          if (s >= SLOTS) begin
            r.status = ST_NO_SLOT;
          end else begin
            busy[s] = 1; ivl[s] = it.period; left[s] = it.repeat_count;
            tag[s] = it.user_tag; base[s] = it.now_time; nxt[s] = 0;
            if (nonempty) begin
              prv[s] = tail; nxt[tail] = 4'(s);
            end else begin
              prv[s] = 0; head = 4'(s); nonempty = 1;
            end
            tail = 4'(s);
            r.slot_number = 4'(s);
          end
        end
        CMD_KILL: begin
          r.slot_number = it.target_slot;
          if (!busy[it.target_slot]) begin
            r.status = ST_KILL_IGN;
          end else begin
            if (scan_ok && scan == it.target_slot) step_scan(it.target_slot);
            unlink(it.target_slot);
            r.retired = 1;
          end
        end
        CMD_TICK: begin
          if (!scan_ok || !busy[scan]) begin
            if (!nonempty) begin
              scan_ok = 0; scan = 0; r.status = ST_LIST_EMPTY;
              pending.push_back(r);
              return;
            end
            scan = head; scan_ok = 1;
          end
          s = scan;
          r.slot_number = 4'(s);
          step_scan(4'(s));
          if (it.now_time - base[s] >= ivl[s]) begin
            r.fired = 1; r.fired_tag = tag[s];
            if (it.accept_fire) begin
              base[s] = it.now_time;
              if (left[s] != 0) begin
                left[s] = left[s] - 1;
                if (left[s] == 0) r.retired = 1;
              end
            end else begin
              r.retired = 1;
            end
            if (r.retired) unlink(4'(s));
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    task check_result(out_item_t got);
      out_item_t exp_r;
      if (pending.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status) report_mismatch("status");
      if (got.slot_number !== exp_r.slot_number) report_mismatch("slot_number");
      if (got.fired !== exp_r.fired) report_mismatch("fired");
      if (got.fired_tag !== exp_r.fired_tag) report_mismatch("fired_tag");
      if (got.retired !== exp_r.retired) report_mismatch("retired");
    endtask
  endclass

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_item_t out_data;

  timer_table_sb timers = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 0;
  int hold_cycles = 0;
  int cycle_count = 0;
  logic [31:0] clock_now = 0;

  multi_timer_scheduler_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Check each result transaction as it is accepted.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) timers.check_result(out_data);
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_recv) begin
      out_ready <= 0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one transaction and wait until it is accepted. The valid line
  // drops only when the sender idles, so back-to-back items keep it high.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    timers.note_input(it);
    @(negedge clk);
  endtask

  function automatic in_item_t make_item(logic [1:0] cmd);
    in_item_t it;
    it.cmd = cmd;
    it.period = $urandom_range(12);
    it.repeat_count = $urandom_range(3);
    it.user_tag = $urandom;
    it.target_slot = 4'($urandom_range(15));
    it.now_time = clock_now;
    it.accept_fire = ($urandom_range(3) != 0);
    return it;
  endfunction

  // Mostly well-formed traffic with a slowly advancing clock.
  task automatic random_item();
    in_item_t it;
    int pick;
    pick = $urandom_range(99);
    clock_now = clock_now + $urandom_range(4);
    if (pick < 30 && timers.active_count() < SLOTS) it = make_item(CMD_SET);
    else if (pick < 45) it = make_item(CMD_KILL);
    else if (pick < 97) it = make_item(CMD_TICK);
    else it = make_item(2'd3);
    if ($urandom_range(19) == 0) begin
      it.period = $urandom;
      it.repeat_count = $urandom;
      it.now_time = $urandom;
    end
    send_item(it);
  endtask

  // Stop offering and wait until every expected result has come.
  task automatic wait_drained();
    in_valid <= 0;
    while (timers.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    in_item_t it;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: empty list, every command, extremes and table full.
    send_item(make_item(CMD_TICK));
    it = make_item(CMD_KILL); it.target_slot = 4'hF; send_item(it);
    send_item(make_item(2'd3));
    it = make_item(CMD_SET); it.period = 0; it.repeat_count = 0;
    it.user_tag = '1; it.now_time = '1; send_item(it);
    it = make_item(CMD_TICK); it.now_time = '0; it.accept_fire = 1; send_item(it);
    it = make_item(CMD_TICK); it.now_time = 32'h7FFF_FFFF; it.accept_fire = 0;
    send_item(it);
    for (int i = 0; i < 17; i++) begin
      it = make_item(CMD_SET);
      it.period = (i == 1) ? '1 : i; it.repeat_count = (i == 2) ? '1 : 1;
      it.now_time = 0;
      send_item(it);
    end
    it = make_item(CMD_TICK); it.now_time = 0; send_item(it);
    it = make_item(CMD_KILL); it.target_slot = 1; send_item(it);
    it = make_item(CMD_KILL); it.target_slot = 1; send_item(it);
    clock_now = 100;

    // Idling phases with random traffic.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 15 : 71) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 15 : 71) : 0;
      for (int n = 0; n < 120; n++) random_item();
      if (ph == 1) wait_drained();
    end

    // Receiver holds off while the sender keeps offering.
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_recv = 1;
    fork
      begin
        while (hold_cycles < 60) @(negedge clk);
        hold_recv = 0;
      end
      for (int n = 0; n < 20; n++) random_item();
    join
    for (int n = 0; n < 40; n++) random_item();

    wait_drained();
    repeat (20) @(posedge clk);
    if (timers.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
